// ----- rtl/byte_budget_lru_cache_tags_assert.svh -----
// Assertion macros shared by the byte-budget LRU tag directory.
`ifndef BYTE_BUDGET_LRU_CACHE_TAGS_ASSERT_SVH
`define BYTE_BUDGET_LRU_CACHE_TAGS_ASSERT_SVH

// Same-cycle implication, sampled on clk, muted while arst_n is low.
`define BBLC_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, muted while arst_n is low.
`define BBLC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bblc_pkg.sv -----
// Types and constants of the byte-budget LRU tag directory.
package bblc_pkg;

	// Command codes of a request beat.
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_STORE  = 1'b1;

	// Budget after reset.
	localparam logic [31:0] MAX_BYTES_RESET = 32'd67108864;

	// Widths of the response fields.
	localparam int SLOT_OUT_W  = 4;
	localparam int EVICT_OUT_W = 5;
	localparam int USED_OUT_W  = 36;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_EVICT_CHECK,
		S_EVICT_APPLY,
		S_INSERT,
		S_DONE
	} bblc_state_t;

	// Operations on the recency cells.
	typedef enum logic [1:0] {
		RK_NONE,
		RK_TOUCH,
		RK_REMOVE,
		RK_INSERT
	} rank_op_t;

endpackage

// ----- rtl/bblc_ifs.sv -----
// Handshake interfaces of the byte-budget LRU tag directory.

// Request channel: one lookup or store per beat.
interface bblc_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] group_id;
	logic [31:0] entry_size;

	modport source (output valid, command, group_id, entry_size, input ready);
	modport sink (input valid, command, group_id, entry_size, output ready);
endinterface

// Response channel: one result per request.
interface bblc_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [3:0]  slot_index;
	logic [31:0] found_size;
	logic [4:0]  evicted_count;
	logic [35:0] used_bytes;
	logic [31:0] hit_total;
	logic [31:0] miss_total;

	modport source (output valid, hit, slot_index, found_size, evicted_count, used_bytes,
		hit_total, miss_total, input ready);
	modport sink (input valid, hit, slot_index, found_size, evicted_count, used_bytes,
		hit_total, miss_total, output ready);
endinterface

// Configuration channel: writes the byte budget.
interface bblc_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] max_memory_bytes;

	modport source (output valid, max_memory_bytes, input ready);
	modport sink (input valid, max_memory_bytes, output ready);
endinterface

// ----- rtl/byte_budget_lru_cache_tags.sv -----
// Top level of the byte-budget LRU tag directory.
//
// Tag-and-size directory for a cache of variable-sized groups held to a byte budget.
// Requests arrive on req (command 0 looks up group_id, command 1 stores group_id with
// entry_size); each produces exactly one response beat on rsp. The cfg channel writes
// the byte budget and is always ready; write it only while no request is in flight.
// One request is worked on at a time, and req.ready is high only while the sequencer idles.
// A sweep reads the tag and size RAMs one slot per cycle with one shared tag comparator.
// A store then evicts least-recent entries as needed, one at a time, each taking a size
// RAM read and a removal, before it inserts the new entry.
// The response sits in an output register: the next request is accepted while it
// waits, and the sequencer holds a finished result only if the previous one is still
// untaken when rsp.ready stays low.
// Reset clears the valid bits, ranks, byte count and hit and miss totals and restores
// the budget to 64 MiB; the RAM contents are left as they are and need no clearing pass.
`include "byte_budget_lru_cache_tags_assert.svh"

module byte_budget_lru_cache_tags import bblc_pkg::*; #(
	parameter int ENTRY_SLOTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	bblc_cfg_if.sink   cfg,
	bblc_req_if.sink   req,
	bblc_rsp_if.source rsp
);

	localparam int SW = $clog2(ENTRY_SLOTS);
	localparam int CW = $clog2(ENTRY_SLOTS + 1);
	localparam int BW = 32 + SW;

	bblc_state_t state_q, state_d;

	// Control registers.
	logic [31:0] max_q;
	logic [BW-1:0] bytes_q;
	logic [31:0] hit_total_q, miss_total_q;
	logic rsp_vld_q;
	logic hit_q;
	logic free_ok_q;
	logic scan_v_s1;

	// Payload registers.
	logic          cmd_q;
	logic [31:0]   id_q, sz_q;
	logic [SW:0]   cnt_q;
	logic [SW-1:0] idx_s1;
	logic [SW-1:0] hslot_q, free_q, lru_q;
	logic [31:0]   hsize_q;
	logic [CW-1:0] evict_q;

	logic                     o_hit_q;
	logic [SLOT_OUT_W-1:0]    o_slot_q;
	logic [31:0]              o_size_q;
	logic [EVICT_OUT_W-1:0]   o_evict_q;
	logic [USED_OUT_W-1:0]    o_used_q;
	logic [31:0]              o_hits_q;
	logic [31:0]              o_misses_q;

	// Datapath wires.
	logic                   req_ready;
	logic [SW-1:0]          scan_addr;
	logic                   scan_issue;
	logic                   match_now;
	logic [SW-1:0]          tag_raddr, size_raddr;
	logic                   ram_we;
	logic [31:0]            tag_rd, size_rd;
	rank_op_t               rank_op;
	logic [SW-1:0]          rank_slot;
	logic [ENTRY_SLOTS-1:0] valid_w;
	logic [SW-1:0]          lru_w;
	logic [CW-1:0]          count_w;
	logic [BW:0]            need_bytes;
	logic                   need_evict;
	logic                   req_acc, rsp_load;

	// Tag and size stores.
	bblc_ram #(.WIDTH(32), .DEPTH(ENTRY_SLOTS)) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_q),
		.wdata (id_q),
		.raddr (tag_raddr),
		.rdata (tag_rd)
	);

	bblc_ram #(.WIDTH(32), .DEPTH(ENTRY_SLOTS)) u_size_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_q),
		.wdata (sz_q),
		.raddr (size_raddr),
		.rdata (size_rd)
	);

	// Recency cells.
	bblc_ranks #(.ENTRY_SLOTS(ENTRY_SLOTS)) u_ranks (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (rank_op),
		.op_slot  (rank_slot),
		.valid    (valid_w),
		.lru_slot (lru_w),
		.count    (count_w)
	);

	// Sweep address and the shared tag compare on the registered read data.
	assign scan_addr  = cnt_q[SW-1:0];
	assign scan_issue = cnt_q < (SW + 1)'(ENTRY_SLOTS);
	assign match_now  = scan_v_s1 && valid_w[idx_s1] && tag_rd == id_q;

	// Budget check: evict unless the cache is empty or the new size fits with a free slot.
	assign need_bytes = (BW + 1)'(bytes_q) + (BW + 1)'(sz_q);
	assign need_evict = count_w != '0 &&
		!(need_bytes <= (BW + 1)'(max_q) && count_w < CW'(ENTRY_SLOTS));

	assign req_acc  = req.valid && req_ready;
	assign rsp_load = state_q == S_DONE && (!rsp_vld_q || rsp.ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:        if (req.valid) state_d = S_SCAN;
			S_SCAN:        if (!scan_issue) state_d = S_DECIDE;
			S_DECIDE:      state_d = (cmd_q == CMD_LOOKUP) ? S_DONE : S_EVICT_CHECK;
			S_EVICT_CHECK: state_d = need_evict ? S_EVICT_APPLY : S_INSERT;
			S_EVICT_APPLY: state_d = S_EVICT_CHECK;
			S_INSERT:      state_d = S_DONE;
			S_DONE:        if (!rsp_vld_q || rsp.ready) state_d = S_IDLE;
			default:       state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: RAM addresses, cell operation and request ready.
	always_comb begin
		req_ready  = 1'b0;
		tag_raddr  = scan_addr;
		size_raddr = scan_addr;
		rank_op    = RK_NONE;
		rank_slot  = hslot_q;
		ram_we     = 1'b0;
		unique case (state_q)
			S_IDLE: req_ready = 1'b1;
			S_DECIDE: begin
				if (hit_q) begin
					rank_op = (cmd_q == CMD_LOOKUP) ? RK_TOUCH : RK_REMOVE;
				end
			end
			S_EVICT_CHECK: size_raddr = lru_w;
			S_EVICT_APPLY: begin
				rank_op   = RK_REMOVE;
				rank_slot = lru_q;
			end
			S_INSERT: begin
				rank_op   = RK_INSERT;
				rank_slot = free_q;
				ram_we    = 1'b1;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			max_q        <= MAX_BYTES_RESET;
			bytes_q      <= '0;
			hit_total_q  <= '0;
			miss_total_q <= '0;
			rsp_vld_q    <= 1'b0;
			hit_q        <= 1'b0;
			free_ok_q    <= 1'b0;
			scan_v_s1    <= 1'b0;
		end else begin
			state_q   <= state_d;
			scan_v_s1 <= state_q == S_SCAN && scan_issue;
			if (cfg.valid && cfg.ready) begin
				max_q <= cfg.max_memory_bytes;
			end
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						hit_q     <= 1'b0;
						free_ok_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (match_now) begin
						hit_q <= 1'b1;
					end
					if (scan_issue && !valid_w[scan_addr]) begin
						free_ok_q <= 1'b1;
					end
				end
				S_DECIDE: begin
					if (cmd_q == CMD_LOOKUP) begin
						if (hit_q) begin
							hit_total_q <= hit_total_q + 32'd1;
						end else begin
							miss_total_q <= miss_total_q + 32'd1;
						end
					end else if (hit_q) begin
						bytes_q   <= bytes_q - BW'(hsize_q);
						free_ok_q <= 1'b1;
					end
				end
				S_EVICT_APPLY: begin
					bytes_q   <= bytes_q - BW'(size_rd);
					free_ok_q <= 1'b1;
				end
				S_INSERT: bytes_q <= bytes_q + BW'(sz_q);
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					cmd_q   <= req.command;
					id_q    <= req.group_id;
					sz_q    <= req.entry_size;
					cnt_q   <= '0;
					evict_q <= '0;
				end
			end
			S_SCAN: begin
				cnt_q  <= cnt_q + (SW + 1)'(1);
				idx_s1 <= scan_addr;
				// The sweep runs upward, so the first free slot seen is the lowest.
				if (scan_issue && !valid_w[scan_addr] && !free_ok_q) begin
					free_q <= scan_addr;
				end
				if (match_now && !hit_q) begin
					hslot_q <= idx_s1;
					hsize_q <= size_rd;
				end
			end
			S_DECIDE: begin
				if (cmd_q == CMD_STORE && hit_q) begin
					evict_q <= CW'(1);
					if (!free_ok_q || hslot_q < free_q) begin
						free_q <= hslot_q;
					end
				end
			end
			S_EVICT_CHECK: lru_q <= lru_w;
			S_EVICT_APPLY: begin
				evict_q <= evict_q + CW'(1);
				if (!free_ok_q || lru_q < free_q) begin
					free_q <= lru_q;
				end
			end
			default: ;
		endcase

		// Result register, loaded when the previous result has been taken.
		if (rsp_load) begin
			o_used_q   <= USED_OUT_W'(bytes_q);
			o_hits_q   <= hit_total_q;
			o_misses_q <= miss_total_q;
			if (cmd_q == CMD_LOOKUP) begin
				o_hit_q   <= hit_q;
				o_slot_q  <= hit_q ? SLOT_OUT_W'(hslot_q) : '0;
				o_size_q  <= hit_q ? hsize_q : '0;
				o_evict_q <= '0;
			end else begin
				o_hit_q   <= 1'b0;
				o_slot_q  <= SLOT_OUT_W'(free_q);
				o_size_q  <= '0;
				o_evict_q <= EVICT_OUT_W'(evict_q);
			end
		end
	end

	// Port drive.
	assign cfg.ready         = 1'b1;
	assign req.ready         = req_ready;
	assign rsp.valid         = rsp_vld_q;
	assign rsp.hit           = o_hit_q;
	assign rsp.slot_index    = o_slot_q;
	assign rsp.found_size    = o_size_q;
	assign rsp.evicted_count = o_evict_q;
	assign rsp.used_bytes    = o_used_q;
	assign rsp.hit_total     = o_hits_q;
	assign rsp.miss_total    = o_misses_q;

	// Insertion always has a known free slot.
	`BBLC_ASSERT_IMPLIES(a_insert_has_free, state_q == S_INSERT, free_ok_q, "insert without a free slot")
	// Eviction removes a slot that is actually occupied.
	`BBLC_ASSERT_IMPLIES(a_evict_valid, state_q == S_EVICT_APPLY, valid_w[lru_q], "evicting an empty slot")
	// A finished item with a free result register shows up on rsp the next cycle.
	`BBLC_ASSERT_NEXT(a_done_to_rsp, state_q == S_DONE && !rsp_vld_q, rsp_vld_q, "result not presented")

endmodule

// ----- rtl/bblc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bblc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/bblc_ranks.sv -----
// Valid bits, recency ranks and occupancy count, one cell per slot.
module bblc_ranks import bblc_pkg::*; #(
	parameter int ENTRY_SLOTS = 16,
	localparam int SW = $clog2(ENTRY_SLOTS),
	localparam int CW = $clog2(ENTRY_SLOTS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rank_op_t               op,
	input  logic [SW-1:0]          op_slot,
	output logic [ENTRY_SLOTS-1:0] valid,
	output logic [SW-1:0]          lru_slot,
	output logic [CW-1:0]          count
);

	logic [ENTRY_SLOTS-1:0] valid_q;
	logic [SW-1:0]          rank_q [ENTRY_SLOTS];
	logic [CW-1:0]          count_q;
	logic [SW-1:0]          op_rank;

	assign op_rank = rank_q[op_slot];

	// Each cell ages, closes a gap or gets cleared on its own compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRY_SLOTS; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			unique case (op)
				RK_TOUCH: begin
					for (int i = 0; i < ENTRY_SLOTS; i++) begin
						if (valid_q[i] && SW'(i) != op_slot && rank_q[i] < op_rank) begin
							rank_q[i] <= rank_q[i] + SW'(1);
						end
					end
					rank_q[op_slot] <= '0;
				end
				RK_REMOVE: begin
					for (int i = 0; i < ENTRY_SLOTS; i++) begin
						if (valid_q[i] && rank_q[i] > op_rank) begin
							rank_q[i] <= rank_q[i] - SW'(1);
						end
					end
					rank_q[op_slot]  <= '0;
					valid_q[op_slot] <= 1'b0;
					count_q          <= count_q - CW'(1);
				end
				RK_INSERT: begin
					for (int i = 0; i < ENTRY_SLOTS; i++) begin
						if (valid_q[i]) begin
							rank_q[i] <= rank_q[i] + SW'(1);
						end
					end
					rank_q[op_slot]  <= '0;
					valid_q[op_slot] <= 1'b1;
					count_q          <= count_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	// Valid ranks form a permutation, so exactly one cell holds count-1: OR its index out.
	always_comb begin
		lru_slot = '0;
		for (int i = 0; i < ENTRY_SLOTS; i++) begin
			if (valid_q[i] && CW'(rank_q[i]) == count_q - CW'(1)) begin
				lru_slot = lru_slot | SW'(i);
			end
		end
	end

	assign valid = valid_q;
	assign count = count_q;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the byte-budget LRU tag directory: directed and random traffic.
module tb_top;
	import bblc_pkg::*;

	localparam int SLOTS = 16;
	localparam int RESET_CYCLES = 10;
	localparam int POOL_SIZE = 24;
	localparam int MAX_REPORTS = 10;
	localparam int RSP_HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 4000;

	// One response beat of the directory.
	typedef struct packed {
		logic        hit;
		logic [3:0]  slot_index;
		logic [31:0] found_size;
		logic [4:0]  evicted_count;
		logic [35:0] used_bytes;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
	} dir_result_t;

	logic clk = 1'b0;
	logic arst_n;

	bblc_cfg_if cfg_ch();
	bblc_req_if req_ch();
	bblc_rsp_if rsp_ch();

	byte_budget_lru_cache_tags #(.ENTRY_SLOTS(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Shadow copy of the directory contents.
	logic [31:0]     tag_m [SLOTS];
	logic [31:0]     size_m [SLOTS];
	bit              valid_m [SLOTS];
	int unsigned     rank_m [SLOTS];
	longint unsigned used_m;
	logic [31:0]     hits_m;
	logic [31:0]     misses_m;
	logic [31:0]     budget_m;

	dir_result_t expected_q[$];
	logic [31:0] id_pool [POOL_SIZE];

	int unsigned mismatch_count = 0;
	int unsigned result_seq = 0;
	int unsigned quiet_cycles = 0;
	bit req_idling = 1'b1;
	bit rsp_idling = 1'b1;
	bit hold_request = 1'b0;
	bit rsp_took = 1'b0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;

	// Free-running clock.
	always #10 clk = ~clk;

	// Make slot s the most recent entry; more recent entries age by one.
	function automatic void promote_slot(int s);
		int unsigned r;
		r = rank_m[s];
		for (int i = 0; i < SLOTS; i++) begin
			if (valid_m[i] && i != s && rank_m[i] < r)
				rank_m[i]++;
		end
		rank_m[s] = 0;
	endfunction

	// Invalidate slot s, release its bytes and close the gap in the ranks.
	function automatic void drop_slot(int s);
		int unsigned r;
		r = rank_m[s];
		valid_m[s] = 1'b0;
		used_m -= 64'(size_m[s]);
		for (int i = 0; i < SLOTS; i++) begin
			if (valid_m[i] && rank_m[i] > r)
				rank_m[i]--;
		end
		rank_m[s] = 0;
	endfunction

	function automatic int find_group(logic [31:0] id);
		for (int i = 0; i < SLOTS; i++) begin
			if (valid_m[i] && tag_m[i] == id)
				return i;
		end
		return -1;
	endfunction

	// Apply one request to the shadow directory and return the response it must produce.
	function automatic dir_result_t predict_directory(logic cmd, logic [31:0] id,
			logic [31:0] sz);
		dir_result_t res;
		int found;
		int lru;
		int count;
		int free_slot;
		int unsigned best;
		bit have_free;
		res = '0;
		found = find_group(id);
		if (cmd == CMD_LOOKUP) begin
			if (found >= 0) begin
				res.hit = 1'b1;
				res.slot_index = found[3:0];
				res.found_size = size_m[found];
				hits_m++;
				promote_slot(found);
			end else begin
				misses_m++;
			end
		end else begin
			// A store replaces an older entry of the same group first.
			if (found >= 0) begin
				drop_slot(found);
				res.evicted_count++;
			end
			// Evict least-recent entries until the size fits and a slot is free.
			forever begin
				count = 0;
				lru = 0;
				best = 0;
				have_free = 1'b0;
				for (int i = 0; i < SLOTS; i++) begin
					if (valid_m[i]) begin
						if (count == 0 || rank_m[i] >= best) begin
							best = rank_m[i];
							lru = i;
						end
						count++;
					end else begin
						have_free = 1'b1;
					end
				end
				if (count == 0)
					break;
				if (used_m + 64'(sz) <= 64'(budget_m) && have_free)
					break;
				drop_slot(lru);
				res.evicted_count++;
			end
			// The new entry takes the lowest free slot and becomes most recent.
			free_slot = 0;
			for (int i = SLOTS - 1; i >= 0; i--) begin
				if (!valid_m[i])
					free_slot = i;
			end
			for (int i = 0; i < SLOTS; i++) begin
				if (valid_m[i])
					rank_m[i]++;
			end
			tag_m[free_slot] = id;
			size_m[free_slot] = sz;
			valid_m[free_slot] = 1'b1;
			rank_m[free_slot] = 0;
			used_m += 64'(sz);
			res.slot_index = free_slot[3:0];
		end
		res.used_bytes = used_m[35:0];
		res.hit_total = hits_m;
		res.miss_total = misses_m;
		return res;
	endfunction

	function automatic void check_field(string field_name, int unsigned seq,
			logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			if (mismatch_count < MAX_REPORTS)
				$display("Result %0d: %s expected 0x%0h, got 0x%0h", seq, field_name, want, got);
			mismatch_count++;
		end
	endfunction

	// Compare every response beat with the oldest prediction.
	always @(posedge clk) begin
		dir_result_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			rsp_took = 1'b1;
			if (expected_q.size() == 0) begin
				if (mismatch_count < MAX_REPORTS)
					$display("Result %0d: response beat with no request outstanding", result_seq);
				mismatch_count++;
			end else begin
				want = expected_q.pop_front();
				check_field("hit", result_seq, 64'(want.hit), 64'(rsp_ch.hit));
				check_field("slot_index", result_seq, 64'(want.slot_index),
					64'(rsp_ch.slot_index));
				check_field("found_size", result_seq, 64'(want.found_size),
					64'(rsp_ch.found_size));
				check_field("evicted_count", result_seq, 64'(want.evicted_count),
					64'(rsp_ch.evicted_count));
				check_field("used_bytes", result_seq, 64'(want.used_bytes),
					64'(rsp_ch.used_bytes));
				check_field("hit_total", result_seq, 64'(want.hit_total),
					64'(rsp_ch.hit_total));
				check_field("miss_total", result_seq, 64'(want.miss_total),
					64'(rsp_ch.miss_total));
			end
			result_seq++;
		end
	end

	// Response side: random stalls after each beat while rsp_idling is set, plus a long hold-off on request.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = RSP_HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (rsp_took) begin
			rsp_took = 1'b0;
			stall_left = rsp_idling ? $urandom_range(0, 6) : 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Watchdog: end the run when no channel moves a beat for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no beat on any channel for %0d cycles", WATCHDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offer one request beat, after a random gap while req_idling is set, and record its prediction once taken.
	task automatic send_request(input logic cmd, input logic [31:0] id, input logic [31:0] sz);
		int unsigned gap;
		gap = req_idling ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.group_id <= id;
		req_ch.entry_size <= sz;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		expected_q.push_back(predict_directory(cmd, id, sz));
		@(negedge clk);
	endtask

	// Stop offering and wait until every response has come back.
	task automatic wait_until_drained();
		req_ch.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Write the byte budget while the directory is idle.
	task automatic write_budget(input logic [31:0] value);
		wait_until_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.max_memory_bytes <= value;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		budget_m = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly ids from a small pool so that hits and duplicates occur, some fully random.
	function automatic logic [31:0] pick_group_id();
		if ($urandom_range(0, 9) < 8)
			return id_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	task automatic send_random_item(input logic [31:0] size_cap);
		logic cmd;
		logic [31:0] sz;
		int unsigned pick;
		cmd = $urandom_range(0, 1) ? CMD_STORE : CMD_LOOKUP;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			sz = $urandom;
		else if (pick == 1)
			sz = 32'h0;
		else if (pick == 2)
			sz = 32'hFFFF_FFFF;
		else
			sz = $urandom_range(0, size_cap);
		send_request(cmd, pick_group_id(), sz);
	endtask

	task automatic run_traffic_phase(input logic [31:0] budget, input logic [31:0] size_cap,
			input int count, input bit idling);
		write_budget(budget);
		req_idling = idling;
		rsp_idling = idling;
		repeat (count)
			send_random_item(size_cap);
		req_idling = 1'b1;
		rsp_idling = 1'b1;
	endtask

	// Extremes of ids and sizes, hits, misses, replacement and oversized entries.
	task automatic test_directed_cases();
		write_budget(MAX_BYTES_RESET);
		send_request(CMD_LOOKUP, 32'h0, $urandom);
		send_request(CMD_STORE, 32'h0, 32'h0);
		send_request(CMD_STORE, 32'hFFFF_FFFF, 32'h100);
		send_request(CMD_LOOKUP, 32'hFFFF_FFFF, $urandom);
		send_request(CMD_LOOKUP, 32'h0, $urandom);
		send_request(CMD_LOOKUP, 32'h1234_5678, $urandom);
		// A store of a cached group replaces the old entry.
		send_request(CMD_STORE, 32'h0, 32'h0300_0000);
		// Two least-recent entries must go before this one fits.
		send_request(CMD_STORE, 32'h5A5A_5A5A, 32'h0200_0000);
		// An entry larger than the budget empties the cache and still goes in.
		send_request(CMD_STORE, 32'hC3C3_C3C3, 32'hFFFF_FFFF);
		send_request(CMD_LOOKUP, 32'hC3C3_C3C3, $urandom);
		send_request(CMD_STORE, 32'h7, 32'h1);
		send_request(CMD_STORE, 32'h8, 32'h2);
		send_request(CMD_STORE, 32'h9, 32'h3);
		send_request(CMD_LOOKUP, 32'h8, $urandom);
		// Fill the budget exactly, then overshoot it by one byte.
		send_request(CMD_STORE, 32'hA, 32'h03FF_FFFA);
		send_request(CMD_STORE, 32'hB, 32'h1);
		send_request(CMD_LOOKUP, 32'h7, $urandom);
		send_request(CMD_LOOKUP, 32'hB, $urandom);
	endtask

	// With no budget every store of a non-zero size empties the cache before it inserts; zero-sized entries fit.
	task automatic test_zero_budget();
		write_budget(32'h0);
		send_request(CMD_STORE, 32'h1, 32'h0);
		send_request(CMD_STORE, 32'h2, 32'h0);
		send_request(CMD_STORE, 32'h3, 32'h5);
		send_request(CMD_LOOKUP, 32'h3, $urandom);
		send_request(CMD_LOOKUP, 32'h1, $urandom);
		send_request(CMD_STORE, 32'h3, 32'h0);
	endtask

	// Hold the response side off while requests keep coming, so the input stalls.
	task automatic test_output_stall();
		write_budget(32'h0000_1000);
		@(posedge clk);
		hold_request = 1'b1;
		@(negedge clk);
		repeat (12)
			send_random_item(32'h400);
		wait_until_drained();
	endtask

	// Random traffic under several budgets, with and without idle cycles.
	task automatic test_random_traffic();
		logic [31:0] budget;
		run_traffic_phase(32'd1000, 32'd300, 110, 1'b1);
		run_traffic_phase(32'hFFFF_FFFF, 32'h0FFF_FFFF, 110, 1'b0);
		budget = $urandom;
		run_traffic_phase(budget, budget >> 2, 110, 1'b1);
		run_traffic_phase(32'h0001_0000, 32'h6000, 110, 1'b1);
		run_traffic_phase(MAX_BYTES_RESET, 32'h0080_0000, 110, 1'b1);
		run_traffic_phase(32'h8000_0000, 32'hFFFF_FFFF, 70, 1'b1);
	endtask

	// Reset, run the tests in turn and report.
	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_LOOKUP;
		req_ch.group_id = 32'h0;
		req_ch.entry_size = 32'h0;
		cfg_ch.valid = 1'b0;
		cfg_ch.max_memory_bytes = 32'h0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			valid_m[i] = 1'b0;
			rank_m[i] = 0;
		end
		used_m = 0;
		hits_m = 32'h0;
		misses_m = 32'h0;
		budget_m = MAX_BYTES_RESET;
		id_pool[0] = 32'h0;
		id_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			id_pool[i] = $urandom;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_zero_budget();
		test_output_stall();
		test_random_traffic();

		wait_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
